### src/fpa_pkg.sv
// fpa_pkg: shared types, codes and constants of the fixed partition allocator
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int DEF_SMALL_BLOCKS = 8;
  localparam int DEF_MID_BLOCKS   = 8;
  localparam int DEF_LARGE_BLOCKS = 8;

  localparam int SIZE_W    = 16;
  localparam int BASE_W    = 24;
  localparam int PORT_IDX_W = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_UNIFORM_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNIFORM_SIZE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    CLS_SMALL,
    CLS_MID,
    CLS_LARGE,
    CLS_POOL
  } class_t;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_TOO_BIG      = 2'd1,
    STATUS_FULL         = 2'd2,
    STATUS_FREE_IGNORED = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic              uniform_mode;
    logic [SIZE_W-1:0] small_size;
    logic [SIZE_W-1:0] mid_size;
    logic [SIZE_W-1:0] large_size;
    logic [SIZE_W-1:0] uniform_size;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    status_t               status;
    logic [PORT_IDX_W-1:0] index;
    logic [BASE_W-1:0]     base;
    logic [SIZE_W-1:0]     size;
  } res_t;

endpackage

### src/fixed_partition_allocator_unit.sv
// fixed_partition_allocator_unit: top level of the fixed partition block allocator
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------------
//   in       | in_valid / in_stall  | op, request_size, free_index
//   out      | out_valid / out_stall| status, granted_index, granted_base, granted_size
//   cfg      | cfg_we               | cfg_index, cfg_data
//
// a free or refused allocate is decided in ST_DECIDE and held in the result register
// until moved into the output; an allocate that scans walks from block 0 to a grant
// or its class's last block, one block per cycle through one shared adder
// reset clears the allocation bits and counters at once, no clearing pass
// one transaction at a time; in_stall is high from acceptance until the result moves
// into the output register, which holds while out_stall is high
`timescale 1ns / 1ps
module fixed_partition_allocator_unit #(
  parameter int SMALL_BLOCKS = fpa_pkg::DEF_SMALL_BLOCKS,
  parameter int MID_BLOCKS   = fpa_pkg::DEF_MID_BLOCKS,
  parameter int LARGE_BLOCKS = fpa_pkg::DEF_LARGE_BLOCKS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [fpa_pkg::SIZE_W-1:0]     request_size,
  input  logic [fpa_pkg::PORT_IDX_W-1:0] free_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [fpa_pkg::PORT_IDX_W-1:0] granted_index,
  output logic [fpa_pkg::BASE_W-1:0]     granted_base,
  output logic [fpa_pkg::SIZE_W-1:0]     granted_size,
  input  logic                           cfg_we,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpa_pkg::SIZE_W-1:0]     cfg_data
);
  import fpa_pkg::*;

  localparam int TOTAL = SMALL_BLOCKS + MID_BLOCKS + LARGE_BLOCKS;
  localparam int IDX_W = $clog2(TOTAL);

  cfg_t              cfg;
  scan_ctl_t         scan_ctl;
  logic [IDX_W-1:0]  scan_idx;
  logic [BASE_W-1:0] scan_acc;
  logic [SIZE_W-1:0] scan_size;
  logic              busy;
  logic              in_take;
  logic              res_valid;
  logic              res_take;
  res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.uniform_mode <= 1'b0;
      cfg.small_size   <= SIZE_W'(16);
      cfg.mid_size     <= SIZE_W'(64);
      cfg.large_size   <= SIZE_W'(256);
      cfg.uniform_size <= SIZE_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UNIFORM_MODE: cfg.uniform_mode <= cfg_data[0];
        REG_SMALL_SIZE:   cfg.small_size   <= cfg_data;
        REG_MID_SIZE:     cfg.mid_size     <= cfg_data;
        REG_LARGE_SIZE:   cfg.large_size   <= cfg_data;
        REG_UNIFORM_SIZE: cfg.uniform_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = busy;
  assign in_take  = in_valid && !busy;
  assign res_take = res_valid && (!out_valid || !out_stall);

  fpa_scan #(
    .SMALL_BLOCKS (SMALL_BLOCKS),
    .MID_BLOCKS   (MID_BLOCKS),
    .LARGE_BLOCKS (LARGE_BLOCKS),
    .IDX_W        (IDX_W)
  ) u_scan (
    .clk  (clk),
    .ctl  (scan_ctl),
    .cfg  (cfg),
    .idx  (scan_idx),
    .acc  (scan_acc),
    .size (scan_size)
  );

  fpa_ctrl #(
    .SMALL_BLOCKS (SMALL_BLOCKS),
    .MID_BLOCKS   (MID_BLOCKS),
    .LARGE_BLOCKS (LARGE_BLOCKS),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_take      (in_take),
    .op           (op),
    .request_size (request_size),
    .free_index   (free_index),
    .cfg          (cfg),
    .busy         (busy),
    .scan_ctl     (scan_ctl),
    .scan_idx     (scan_idx),
    .scan_acc     (scan_acc),
    .scan_size    (scan_size),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status        <= res.status;
      granted_index <= res.index;
      granted_base  <= res.base;
      granted_size  <= res.size;
    end
  end

endmodule

### src/fpa_scan.sv
// fpa_scan: block walker with the shared base address accumulator
`timescale 1ns / 1ps
module fpa_scan #(
  parameter int SMALL_BLOCKS = 8,
  parameter int MID_BLOCKS   = 8,
  parameter int LARGE_BLOCKS = 8,
  parameter int IDX_W        = 5
) (
  input  logic                      clk,
  input  fpa_pkg::scan_ctl_t        ctl,
  input  fpa_pkg::cfg_t             cfg,
  output logic [IDX_W-1:0]          idx,
  output logic [fpa_pkg::BASE_W-1:0] acc,
  output logic [fpa_pkg::SIZE_W-1:0] size
);
  import fpa_pkg::*;

  localparam logic [IDX_W-1:0] MID_FIRST   = IDX_W'(SMALL_BLOCKS);
  localparam logic [IDX_W-1:0] LARGE_FIRST = IDX_W'(SMALL_BLOCKS + MID_BLOCKS);

  // size of the block under the walker
  always_comb begin
    if (cfg.uniform_mode) begin
      size = cfg.uniform_size;
    end else if (idx < MID_FIRST) begin
      size = cfg.small_size;
    end else if (idx < LARGE_FIRST) begin
      size = cfg.mid_size;
    end else begin
      size = cfg.large_size;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      idx <= '0;
      acc <= '0;
    end else if (ctl.step) begin
      idx <= idx + IDX_W'(1);
      acc <= acc + BASE_W'(size);
    end
  end

endmodule

### src/fpa_ctrl.sv
// fpa_ctrl: sequencer, allocation bits, class counters and result register
`timescale 1ns / 1ps
module fpa_ctrl #(
  parameter int SMALL_BLOCKS = 8,
  parameter int MID_BLOCKS   = 8,
  parameter int LARGE_BLOCKS = 8,
  parameter int IDX_W        = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_take,
  input  logic                           op,
  input  logic [fpa_pkg::SIZE_W-1:0]     request_size,
  input  logic [fpa_pkg::PORT_IDX_W-1:0] free_index,
  input  fpa_pkg::cfg_t                  cfg,
  output logic                           busy,
  output fpa_pkg::scan_ctl_t             scan_ctl,
  input  logic [IDX_W-1:0]               scan_idx,
  input  logic [fpa_pkg::BASE_W-1:0]     scan_acc,
  input  logic [fpa_pkg::SIZE_W-1:0]     scan_size,
  output logic                           res_valid,
  output fpa_pkg::res_t                  res,
  input  logic                           res_take
);
  import fpa_pkg::*;

  localparam int TOTAL = SMALL_BLOCKS + MID_BLOCKS + LARGE_BLOCKS;
  localparam int S_W   = $clog2(SMALL_BLOCKS + 1);
  localparam int M_W   = $clog2(MID_BLOCKS + 1);
  localparam int L_W   = $clog2(LARGE_BLOCKS + 1);
  localparam int P_W   = $clog2(TOTAL + 1);

  localparam logic [IDX_W-1:0] MID_FIRST   = IDX_W'(SMALL_BLOCKS);
  localparam logic [IDX_W-1:0] LARGE_FIRST = IDX_W'(SMALL_BLOCKS + MID_BLOCKS);
  localparam logic [IDX_W-1:0] SMALL_LAST  = IDX_W'(SMALL_BLOCKS - 1);
  localparam logic [IDX_W-1:0] MID_LAST    = IDX_W'(SMALL_BLOCKS + MID_BLOCKS - 1);
  localparam logic [IDX_W-1:0] TOTAL_LAST  = IDX_W'(TOTAL - 1);

  state_t               state, state_next;
  logic [TOTAL-1:0]     bits;
  logic [S_W-1:0]       small_in_use, small_in_use_next;
  logic [M_W-1:0]       mid_in_use, mid_in_use_next;
  logic [L_W-1:0]       large_in_use, large_in_use_next;
  logic [P_W-1:0]       pool_in_use, pool_in_use_next;

  logic                 op_q;
  logic [SIZE_W-1:0]    req_q;
  logic [PORT_IDX_W-1:0] fidx_q;
  class_t               cls_q, cls_next;
  res_t                 res_next;
  logic                 res_load;

  logic [IDX_W-1:0]     fidx_ext;
  logic                 fidx_ok;
  logic                 free_ok;
  logic                 too_big;
  logic                 has_room;
  logic [IDX_W-1:0]     lo, last;
  logic                 grant;
  logic                 bit_set;
  logic                 bit_clr;

  assign fidx_ext = IDX_W'(fidx_q);
  assign fidx_ok  = int'(fidx_q) < TOTAL;
  assign free_ok  = fidx_ok && bits[fidx_ext];
  assign too_big  = req_q > cfg.large_size;

  // class choice
  always_comb begin
    has_room = 1'b1;
    cls_next = CLS_LARGE;
    if (cfg.uniform_mode) begin
      cls_next = CLS_POOL;
      has_room = pool_in_use < P_W'(TOTAL);
    end else if (req_q <= cfg.small_size && small_in_use < S_W'(SMALL_BLOCKS)) begin
      cls_next = CLS_SMALL;
    end else if (req_q <= cfg.mid_size && mid_in_use < M_W'(MID_BLOCKS)) begin
      cls_next = CLS_MID;
    end else begin
      has_room = large_in_use < L_W'(LARGE_BLOCKS);
    end
  end

  always_comb begin
    case (cls_q)
      CLS_SMALL: begin
        lo   = '0;
        last = SMALL_LAST;
      end
      CLS_MID: begin
        lo   = MID_FIRST;
        last = MID_LAST;
      end
      CLS_LARGE: begin
        lo   = LARGE_FIRST;
        last = TOTAL_LAST;
      end
      default: begin
        lo   = '0;
        last = TOTAL_LAST;
      end
    endcase
  end

  assign grant = (state == ST_SCAN) && scan_idx >= lo && scan_idx <= last && !bits[scan_idx];

  always_comb begin
    state_next        = state;
    scan_ctl          = '0;
    res_load          = 1'b0;
    res_next          = '0;
    res_next.status   = STATUS_OK;
    bit_set           = 1'b0;
    bit_clr           = 1'b0;
    small_in_use_next = small_in_use;
    mid_in_use_next   = mid_in_use;
    large_in_use_next = large_in_use;
    pool_in_use_next  = pool_in_use;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (op_q == OP_FREE) begin
          res_load   = 1'b1;
          state_next = ST_RESP;
          if (!free_ok) begin
            res_next.status = STATUS_FREE_IGNORED;
          end else begin
            bit_clr = 1'b1;
            if (cfg.uniform_mode) begin
              pool_in_use_next = (pool_in_use != '0) ? pool_in_use - P_W'(1) : pool_in_use;
            end else if (fidx_ext < MID_FIRST) begin
              small_in_use_next = (small_in_use != '0) ? small_in_use - S_W'(1) : small_in_use;
            end else if (fidx_ext < LARGE_FIRST) begin
              mid_in_use_next = (mid_in_use != '0) ? mid_in_use - M_W'(1) : mid_in_use;
            end else begin
              large_in_use_next = (large_in_use != '0) ? large_in_use - L_W'(1) : large_in_use;
            end
          end
        end else if (too_big) begin
          res_load        = 1'b1;
          res_next.status = STATUS_TOO_BIG;
          state_next      = ST_RESP;
        end else if (!has_room) begin
          res_load        = 1'b1;
          res_next.status = STATUS_FULL;
          state_next      = ST_RESP;
        end else begin
          scan_ctl.clear = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (grant) begin
          bit_set         = 1'b1;
          res_load        = 1'b1;
          res_next.status = STATUS_OK;
          res_next.index  = PORT_IDX_W'(scan_idx);
          res_next.base   = scan_acc;
          res_next.size   = scan_size;
          state_next      = ST_RESP;
          case (cls_q)
            CLS_SMALL: small_in_use_next = small_in_use + S_W'(1);
            CLS_MID:   mid_in_use_next   = mid_in_use + M_W'(1);
            CLS_LARGE: large_in_use_next = large_in_use + L_W'(1);
            default:   pool_in_use_next  = pool_in_use + P_W'(1);
          endcase
        end else if (scan_idx == last) begin
          res_load        = 1'b1;
          res_next.status = STATUS_FULL;
          state_next      = ST_RESP;
        end else begin
          scan_ctl.step = 1'b1;
        end
      end
      ST_RESP: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_RESP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bits         <= '0;
      small_in_use <= '0;
      mid_in_use   <= '0;
      large_in_use <= '0;
      pool_in_use  <= '0;
    end else begin
      state        <= state_next;
      small_in_use <= small_in_use_next;
      mid_in_use   <= mid_in_use_next;
      large_in_use <= large_in_use_next;
      pool_in_use  <= pool_in_use_next;
      if (bit_set) begin
        bits[scan_idx] <= 1'b1;
      end
      if (bit_clr) begin
        bits[fidx_ext] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q   <= op;
      req_q  <= request_size;
      fidx_q <= free_index;
    end
    if (state == ST_DECIDE) begin
      cls_q <= cls_next;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  a_grant_sets_bit: assert property (@(posedge clk) disable iff (rst)
    grant |=> bits[$past(scan_idx)])
    else $error("granted block not marked allocated");

  a_free_clears_bit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && op_q == OP_FREE && free_ok) |=> !bits[$past(fidx_ext)])
    else $error("freed block still marked allocated");

  a_counters_bounded: assert property (@(posedge clk) disable iff (rst)
    small_in_use <= S_W'(SMALL_BLOCKS) && mid_in_use <= M_W'(MID_BLOCKS) &&
    large_in_use <= L_W'(LARGE_BLOCKS) && pool_in_use <= P_W'(TOTAL))
    else $error("use counter beyond its block count");

  a_take_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_take) |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after result");

endmodule
